### hw/rtl/mpr_pkg.sv
// package for the maze path recorder: sizes, move codes, decode and fold functions
package mpr_pkg;

  localparam int PATH_DEPTH = 64;
  localparam int IDX_W      = $clog2(PATH_DEPTH);
  localparam int CNT_W      = $clog2(PATH_DEPTH + 1);
  localparam int LEN_W      = 7;

  typedef enum logic [1:0] {
    MV_L = 2'd0,
    MV_F = 2'd1,
    MV_R = 2'd2,
    MV_B = 2'd3
  } move_t;

  typedef struct packed {
    logic  none;
    move_t mv;
  } pick_t;

  typedef struct packed {
    logic  hit;
    move_t mv;
  } fold_t;

  typedef struct packed {
    move_t             move;
    logic              no_move;
    logic              overflow;
    logic [LEN_W-1:0]  path_length;
  } res_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(PATH_DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(PATH_DEPTH - 1) : i - IDX_W'(1);
  endfunction

  // left hand rule: left, forward, right, back
  function automatic pick_t pick_move(input logic l, input logic f,
                                      input logic r, input logic b);
    pick_t p;
    p.none = 1'b0;
    p.mv   = MV_L;
    priority if (l) begin
      p.mv = MV_L;
    end else if (f) begin
      p.mv = MV_F;
    end else if (r) begin
      p.mv = MV_R;
    end else if (b) begin
      p.mv = MV_B;
    end else begin
      p.none = 1'b1;
    end
    return p;
  endfunction

  // fold of (below, back, mv)
  function automatic fold_t fold_rule(input move_t below, input move_t mv);
    fold_t f;
    f.hit = 1'b0;
    f.mv  = MV_L;
    unique case (mv)
      MV_L: begin
        unique case (below)
          MV_L: begin f.hit = 1'b1; f.mv = MV_F; end
          MV_F: begin f.hit = 1'b1; f.mv = MV_R; end
          MV_R: begin f.hit = 1'b1; f.mv = MV_B; end
          default: f.hit = 1'b0;
        endcase
      end
      MV_F: begin
        unique case (below)
          MV_L: begin f.hit = 1'b1; f.mv = MV_R; end
          MV_F: begin f.hit = 1'b1; f.mv = MV_B; end
          default: f.hit = 1'b0;
        endcase
      end
      MV_R: begin
        if (below == MV_L) begin
          f.hit = 1'b1;
          f.mv  = MV_B;
        end
      end
      default: f.hit = 1'b0;
    endcase
    return f;
  endfunction

endpackage

### hw/rtl/mpr_req_if.sv
// request channel: junction or replay item
interface mpr_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic open_left;
  logic open_forward;
  logic open_right;
  logic open_back;

  modport source (output valid, req_type, open_left, open_forward, open_right, open_back,
                  input ready);
  modport sink (input valid, req_type, open_left, open_forward, open_right, open_back,
                output ready);
endinterface

### hw/rtl/mpr_res_if.sv
// result channel: move and status item
interface mpr_res_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               move;
  logic                     no_move;
  logic                     overflow;
  logic [mpr_pkg::LEN_W-1:0] path_length;

  modport source (output valid, move, no_move, overflow, path_length, input ready);
  modport sink (input valid, move, no_move, overflow, path_length, output ready);
endinterface

### hw/rtl/mpr_ram.sv
// generic single write port ram with registered read
module mpr_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/mpr_ctrl.sv
// sequencer: path indices, move pick, fold and ram read-modify-write
module mpr_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  mpr_req_if.sink                     req,
  output logic                        ram_we,
  output logic [mpr_pkg::IDX_W-1:0]   ram_waddr,
  output logic [1:0]                  ram_wdata,
  output logic                        ram_re,
  output logic [mpr_pkg::IDX_W-1:0]   ram_raddr,
  input  logic [1:0]                  ram_rdata,
  output logic                        res_load,
  output mpr_pkg::res_t               res,
  input  logic                        res_free
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t                    state, state_next;
  logic [mpr_pkg::IDX_W-1:0] newest, newest_next;
  logic [mpr_pkg::IDX_W-1:0] oldest, oldest_next;
  logic [mpr_pkg::CNT_W-1:0] count, count_next;
  mpr_pkg::move_t            top, top_next;
  logic                      is_replay;
  mpr_pkg::pick_t            pick;
  mpr_pkg::fold_t            fold;
  logic                      accept;
  logic                      do_fold;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign ram_re    = accept;
  assign ram_raddr = req.req_type ? oldest : mpr_pkg::idx_dec(newest);
  assign fold      = mpr_pkg::fold_rule(mpr_pkg::move_t'(ram_rdata), pick.mv);
  assign do_fold   = (pick.mv != mpr_pkg::MV_B) && (count > mpr_pkg::CNT_W'(1)) &&
                     (top == mpr_pkg::MV_B) && fold.hit;

  always_ff @(posedge clk) begin
    if (accept) begin
      is_replay <= req.req_type;
      pick      <= mpr_pkg::pick_move(req.open_left, req.open_forward,
                                      req.open_right, req.open_back);
    end
  end

  always_comb begin
    state_next  = state;
    newest_next = newest;
    oldest_next = oldest;
    count_next  = count;
    top_next    = top;
    ram_we      = 1'b0;
    ram_waddr   = newest;
    ram_wdata   = pick.mv;
    res_load    = 1'b0;
    res.move    = mpr_pkg::MV_L;
    res.no_move = 1'b0;
    res.overflow = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (res_free) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
          if (is_replay) begin
            if (count == '0) begin
              res.no_move = 1'b1;
            end else begin
              res.move    = mpr_pkg::move_t'(ram_rdata);
              oldest_next = mpr_pkg::idx_inc(oldest);
              count_next  = count - mpr_pkg::CNT_W'(1);
            end
          end else if (pick.none) begin
            res.no_move = 1'b1;
          end else begin
            res.move = pick.mv;
            if (do_fold) begin
              ram_we      = 1'b1;
              ram_waddr   = mpr_pkg::idx_dec(newest);
              ram_wdata   = fold.mv;
              newest_next = mpr_pkg::idx_dec(newest);
              top_next    = fold.mv;
              count_next  = count - mpr_pkg::CNT_W'(1);
            end else if (count == mpr_pkg::CNT_W'(mpr_pkg::PATH_DEPTH)) begin
              res.overflow = 1'b1;
            end else begin
              newest_next = (count == '0) ? oldest : mpr_pkg::idx_inc(newest);
              ram_we      = 1'b1;
              ram_waddr   = newest_next;
              ram_wdata   = pick.mv;
              top_next    = pick.mv;
              count_next  = count + mpr_pkg::CNT_W'(1);
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
    res.path_length = mpr_pkg::LEN_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      newest <= '0;
      oldest <= '0;
      count  <= '0;
    end else begin
      state  <= state_next;
      newest <= newest_next;
      oldest <= oldest_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= mpr_pkg::CNT_W'(mpr_pkg::PATH_DEPTH))
    else $error("entry count above depth");

  a_we_in_exec: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_EXEC) && res_load)
    else $error("ram write outside result cycle");

  a_load_to_idle: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (state == ST_IDLE))
    else $error("sequencer did not return to idle");

  a_read_on_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC) && !req.ready)
    else $error("item accepted without entering exec");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (res_load && is_replay && (count != '0)) |=>
      (count == $past(count) - mpr_pkg::CNT_W'(1)))
    else $error("replay pop did not decrement count");

endmodule

### hw/rtl/maze_path_recorder_simplifier.sv
// top level: maze path recorder with path folding and result register
// flow: the accepting edge registers the ram read; the exec state then updates the path and loads
// the result register, stalling while it still holds an untaken result; no new item is accepted before that load
// the input is free again while the result waits in the output register
// reset: synchronous rst empties the path store (count and indices to zero)
// ram contents are not cleared; only data read from held entries is ever used
module maze_path_recorder_simplifier (
  input  logic        clk,
  input  logic        rst,
  mpr_req_if.sink     req,
  mpr_res_if.source   res
);

  logic                      ram_we;
  logic [mpr_pkg::IDX_W-1:0] ram_waddr;
  logic [1:0]                ram_wdata;
  logic                      ram_re;
  logic [mpr_pkg::IDX_W-1:0] ram_raddr;
  logic [1:0]                ram_rdata;
  logic                      res_load;
  mpr_pkg::res_t             res_d;
  mpr_pkg::res_t             res_q;
  logic                      res_valid;
  logic                      res_free;

  assign res_free = !res_valid || res.ready;

  mpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_load  (res_load),
    .res       (res_d),
    .res_free  (res_free)
  );

  mpr_ram #(
    .WIDTH (2),
    .DEPTH (mpr_pkg::PATH_DEPTH)
  ) u_path_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign res.valid       = res_valid;
  assign res.move        = res_q.move;
  assign res.no_move     = res_q.no_move;
  assign res.overflow    = res_q.overflow;
  assign res.path_length = res_q.path_length;

endmodule
